### rtl/okvt_pkg.sv
package okvt_pkg;

    // Request codes carried in the input tuser
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_UPDATE  = 3'd1;
    localparam logic [2:0] OP_UPSERT  = 3'd2;
    localparam logic [2:0] OP_ERASE   = 3'd3;
    localparam logic [2:0] OP_LOOKUP  = 3'd4;
    localparam logic [2:0] OP_READPOS = 3'd5;

    // Fixed field widths on the stream ports
    localparam int OP_W        = 3;
    localparam int KEY_FIELD_W = 32;
    localparam int VAL_FIELD_W = 32;
    localparam int POS_W       = 8;
    localparam int CNT_FIELD_W = 9;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

endpackage

### rtl/okvt_store.sv
module okvt_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int KEY_W  = 32,
    parameter int VAL_W  = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [VAL_W-1:0]  wr_value,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [KEY_W-1:0]  rd_key,
    output logic [VAL_W-1:0]  rd_value
);

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0] value_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

### rtl/ordered_key_value_table_core.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser[2:0] operation; tdata key[31:0], value[63:32], position[71:64]
// m_axis    out  tuser[0] success; tdata found_key[31:0], found_value[63:32],
//                entry_count[72:64], zero[79:73]
//
// Search requests read and compare the stored entries in order until the key matches or
// the entries run out. Erase then moves each later entry down by one slot; read position
// reads the entry at that position, and skips the read when it is out of range; an unused
// operation code goes straight to the result. The single read port of the entry store and
// one key comparator make the search and compaction step through one entry at a time.
// Reset clears the entry count, state and output valid; entries are undefined until written.
// One request at a time: s_axis_tready is high only when idle; a result waits in the
// output register and a finished request holds until that register is free.
module ordered_key_value_table_core
    import okvt_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // key [31:0], value [63:32], position [71:64]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [2:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // found_key [31:0], found_value [63:32], entry_count [72:64], zero [79:73]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // success [0]
    output logic                   m_axis_tuser
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRD   = 4'd1;
    localparam logic [3:0] ST_SCMP  = 4'd2;
    localparam logic [3:0] ST_EXEC  = 4'd3;
    localparam logic [3:0] ST_ERD   = 4'd4;
    localparam logic [3:0] ST_EWR   = 4'd5;
    localparam logic [3:0] ST_PRD   = 4'd6;
    localparam logic [3:0] ST_PDATA = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   found_reg, found_next;
    logic                   ok_reg, ok_next;
    logic [KEY_FIELD_W-1:0] fk_reg, fk_next;
    logic [VAL_FIELD_W-1:0] fv_reg, fv_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;

    logic [CNT_W-1:0]       idx_plus;
    logic                   can_append;
    logic                   pos_in_range;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_BITS-1:0]    wr_key;
    logic [VALUE_BITS-1:0]  wr_value;
    logic [IDX_W-1:0]       rd_addr;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_value;

    okvt_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .KEY_W  (KEY_BITS),
        .VAL_W  (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign idx_plus      = idx_reg + 1'b1;
    assign can_append    = (count_reg < CAP_CNT);
    assign pos_in_range  = (CMP_W'(pos_reg) < CMP_W'(count_reg));
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Pick the read address for the current step
    always_comb
    begin
        case (state_reg)
            ST_ERD:            rd_addr = idx_plus[IDX_W-1:0];
            ST_PRD, ST_PDATA:  rd_addr = IDX_W'(pos_reg);
            default:           rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    // Sequencer: search, apply, compact, read by position, report
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        ok_next      = ok_reg;
        fk_next      = fk_reg;
        fv_next      = fv_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[IDX_W-1:0];
        wr_key       = key_reg;
        wr_value     = val_reg;

        // Drop a result once the sink takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    key_next   = KEY_BITS'(s_axis_tdata[31:0]);
                    val_next   = VALUE_BITS'(s_axis_tdata[63:32]);
                    pos_next   = s_axis_tdata[71:64];
                    idx_next   = '0;
                    found_next = 1'b0;
                    ok_next    = 1'b0;
                    fk_next    = '0;
                    fv_next    = '0;
                    case (s_axis_tuser)
                        OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_LOOKUP:
                            state_next = ST_SRD;
                        OP_READPOS:
                            state_next = ST_PRD;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SRD:
            begin
                // End of the stored entries means the key is absent
                if (idx_reg == count_reg)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                if (rd_key == key_reg)
                begin
                    found_next = 1'b1;
                    fv_next    = VAL_FIELD_W'(rd_value);
                    state_next = ST_EXEC;
                end
                else
                begin
                    idx_next   = idx_plus;
                    state_next = ST_SRD;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        // Only a lookup reports the value found by the search
                        fv_next = '0;
                        if (!found_reg && can_append)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    OP_UPDATE, OP_UPSERT:
                    begin
                        fv_next = '0;
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            ok_next = 1'b1;
                        end
                        else if (op_reg == OP_UPSERT && can_append)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (found_reg)
                        begin
                            state_next = ST_ERD;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        ok_next = found_reg;
                        if (!found_reg)
                        begin
                            fv_next = '0;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_ERD:
            begin
                // Last entry reached: shrink the table
                if (idx_plus == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                    fv_next    = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_EWR;
                end
            end
            ST_EWR:
            begin
                // Move the next entry down by one
                wr_en      = 1'b1;
                wr_key     = rd_key;
                wr_value   = rd_value;
                idx_next   = idx_plus;
                state_next = ST_ERD;
            end
            ST_PRD:
            begin
                if (pos_in_range)
                begin
                    state_next = ST_PDATA;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PDATA:
            begin
                fk_next    = KEY_FIELD_W'(rd_key);
                fv_next    = VAL_FIELD_W'(rd_value);
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = ok_reg;
                    m_data_next  = {7'b0, CNT_FIELD_W'(count_reg), fv_reg, fk_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        ok_reg     <= ok_next;
        fk_reg     <= fk_next;
        fv_reg     <= fv_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_compare_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCMP |-> $past(state_reg) == ST_SRD)
        else $error("key compare without a preceding read");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && state_reg == ST_IDLE))
        else $error("store written while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done step");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");
`endif

endmodule
